// ===== design/jbt_pkg.sv =====
// Shared types, codes and helper functions for the JSON byte tokenizer.
package jbt_pkg;

    // Lexer modes
    localparam logic [3:0] M_LOOKUP  = 4'd0;
    localparam logic [3:0] M_STR     = 4'd1;
    localparam logic [3:0] M_ESC     = 4'd2;
    localparam logic [3:0] M_UESC    = 4'd3;
    localparam logic [3:0] M_INT     = 4'd4;
    localparam logic [3:0] M_FRAC    = 4'd5;
    localparam logic [3:0] M_EXPSIGN = 4'd6;
    localparam logic [3:0] M_EXP     = 4'd7;
    localparam logic [3:0] M_TRUE    = 4'd8;
    localparam logic [3:0] M_FALSE   = 4'd9;
    localparam logic [3:0] M_NULL    = 4'd10;

    // Token kinds
    localparam logic [3:0] K_COLON    = 4'd0;
    localparam logic [3:0] K_COMMA    = 4'd1;
    localparam logic [3:0] K_LBRACE   = 4'd2;
    localparam logic [3:0] K_RBRACE   = 4'd3;
    localparam logic [3:0] K_LBRACKET = 4'd4;
    localparam logic [3:0] K_RBRACKET = 4'd5;
    localparam logic [3:0] K_TRUE     = 4'd6;
    localparam logic [3:0] K_STRBEGIN = 4'd9;
    localparam logic [3:0] K_STRBYTE  = 4'd10;
    localparam logic [3:0] K_STREND   = 4'd11;
    localparam logic [3:0] K_INT      = 4'd12;
    localparam logic [3:0] K_REAL     = 4'd13;
    localparam logic [3:0] K_ERR      = 4'd14;

    // Error codes
    localparam logic [3:0] E_BAD_UTF8    = 4'd1;
    localparam logic [3:0] E_LONG_UTF8   = 4'd2;
    localparam logic [3:0] E_BAD_UESC    = 4'd3;
    localparam logic [3:0] E_BAD_EXP     = 4'd4;
    localparam logic [3:0] E_BAD_LIT     = 4'd5;
    localparam logic [3:0] E_EOF_STR     = 4'd8;
    localparam logic [3:0] E_EOF_EXPSIGN = 4'd9;
    localparam logic [3:0] E_EOF_LIT     = 4'd10;

    // Result queue depth
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_value;
    } in_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  string_byte;
        logic [63:0] int_magnitude;
        logic        is_negative;
        logic [63:0] frac_digits;
        logic [9:0]  frac_count;
        logic [15:0] exp_magnitude;
        logic        exp_is_negative;
        logic [3:0]  error_code;
        logic        last_of_run;
    } tok_t;

    // Up to two tokens produced by one input beat
    typedef struct packed {
        logic a_v;
        logic b_v;
        tok_t a;
        tok_t b;
    } push_t;

    function automatic tok_t mk_tok(logic [3:0] kind, logic [7:0] sbyte, logic [3:0] code);
        tok_t t;
        t = '0;
        t.token_kind  = kind;
        t.string_byte = sbyte;
        t.error_code  = code;
        return t;
    endfunction

    function automatic logic [2:0] lit_len(logic [1:0] which);
        return (which == 2'd1) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(logic [1:0] which, logic [2:0] off);
        logic [7:0] c;
        c = 8'h00;
        case (which)
            2'd0:
            begin
                case (off)
                    3'd0: c = 8'h74; // t
                    3'd1: c = 8'h72; // r
                    3'd2: c = 8'h75; // u
                    3'd3: c = 8'h65; // e
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (off)
                    3'd0: c = 8'h66; // f
                    3'd1: c = 8'h61; // a
                    3'd2: c = 8'h6c; // l
                    3'd3: c = 8'h73; // s
                    3'd4: c = 8'h65; // e
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (off)
                    3'd0: c = 8'h6e; // n
                    3'd1: c = 8'h75; // u
                    3'd2: c = 8'h6c; // l
                    3'd3: c = 8'h6c; // l
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// ===== design/jbt_lexer.sv =====
// Lexer state registers and the per-byte next-state and token logic.
module jbt_lexer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  jbt_pkg::in_t   item,
    input  logic           utf8_en,
    output jbt_pkg::push_t push
);

    logic [3:0]  mode_reg, mode_next;
    logic [1:0]  urem_reg, urem_next;
    logic [1:0]  ucon_reg, ucon_next;
    logic [2:0]  loff_reg, loff_next;
    logic        minus_reg, minus_next;
    logic [63:0] iacc_reg, iacc_next;
    logic [63:0] facc_reg, facc_next;
    logic [9:0]  flen_reg, flen_next;
    logic [15:0] eacc_reg, eacc_next;
    logic        eminus_reg, eminus_next;
    logic [15:0] cu_reg, cu_next;
    logic        err_reg, err_next;

    logic [7:0]     bv;
    logic           is_dig;
    logic [3:0]     dv;
    jbt_pkg::tok_t  num_tok;
    jbt_pkg::tok_t  ta, tb, lk;
    logic           ta_v, tb_v, lk_v, do_lk, ok;
    logic [4:0]     hx;
    logic [1:0]     which;
    logic [19:0]    e20;

    assign bv     = item.byte_value;
    assign is_dig = (bv >= 8'h30) && (bv <= 8'h39);
    assign dv     = bv[3:0];
    assign which  = mode_reg[1:0]; // TRUE/FALSE/NULL map to 0/1/2
    assign hx     = jbt_pkg::hex_val(bv);
    assign e20    = ({4'd0, eacc_reg} << 3) + ({4'd0, eacc_reg} << 1) + {16'd0, dv};

    always_comb
    begin
        num_tok = '0;
        num_tok.token_kind    = (mode_reg == jbt_pkg::M_INT) ? jbt_pkg::K_INT : jbt_pkg::K_REAL;
        num_tok.int_magnitude = iacc_reg;
        num_tok.is_negative   = minus_reg;
        if (mode_reg != jbt_pkg::M_INT)
        begin
            num_tok.frac_digits     = facc_reg;
            num_tok.frac_count      = flen_reg;
            num_tok.exp_magnitude   = eacc_reg;
            num_tok.exp_is_negative = eminus_reg;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        urem_next   = urem_reg;
        ucon_next   = ucon_reg;
        loff_next   = loff_reg;
        minus_next  = minus_reg;
        iacc_next   = iacc_reg;
        facc_next   = facc_reg;
        flen_next   = flen_reg;
        eacc_next   = eacc_reg;
        eminus_next = eminus_reg;
        cu_next     = cu_reg;
        err_next    = err_reg;
        ta = '0; tb = '0; lk = '0;
        ta_v = 1'b0; tb_v = 1'b0; lk_v = 1'b0; do_lk = 1'b0; ok = 1'b0;

        if (fire && !err_reg)
        begin
            if (item.req_type)
            begin
                case (mode_reg)
                    jbt_pkg::M_STR, jbt_pkg::M_ESC, jbt_pkg::M_UESC:
                    begin
                        ta_v = 1'b1; ta = jbt_pkg::mk_tok(jbt_pkg::K_ERR, 8'd0, jbt_pkg::E_EOF_STR);
                        err_next = 1'b1;
                    end
                    jbt_pkg::M_INT, jbt_pkg::M_FRAC, jbt_pkg::M_EXP:
                    begin
                        ta_v = 1'b1; ta = num_tok;
                    end
                    jbt_pkg::M_EXPSIGN:
                    begin
                        ta_v = 1'b1;
                        ta = jbt_pkg::mk_tok(jbt_pkg::K_ERR, 8'd0, jbt_pkg::E_EOF_EXPSIGN);
                        err_next = 1'b1;
                    end
                    jbt_pkg::M_TRUE, jbt_pkg::M_FALSE, jbt_pkg::M_NULL:
                    begin
                        ta_v = 1'b1;
                        ta = jbt_pkg::mk_tok(jbt_pkg::K_ERR, 8'd0,
                                             jbt_pkg::E_EOF_LIT + {2'd0, which});
                        err_next = 1'b1;
                    end
                    default: ;
                endcase
                if (!err_next)
                begin
                    minus_next = 1'b0; iacc_next = '0; facc_next = '0; flen_next = '0;
                    eacc_next = '0; eminus_next = 1'b0;
                    mode_next = jbt_pkg::M_LOOKUP;
                end
            end
            else
            begin
                case (mode_reg)
                    jbt_pkg::M_STR:
                    begin
                        if (utf8_en && urem_reg != 2'd0)
                        begin
                            case (ucon_reg)
                                2'd1: ok = bv >= 8'ha0 && bv <= 8'hbf;
                                2'd2: ok = bv >= 8'h90 && bv <= 8'hbf;
                                2'd3: ok = bv >= 8'h80 && bv <= 8'h8f;
                                default: ok = bv[7:6] == 2'b10;
                            endcase
                            ta_v = 1'b1;
                            if (!ok)
                            begin
                                ta = jbt_pkg::mk_tok(jbt_pkg::K_ERR, 8'd0, jbt_pkg::E_BAD_UTF8);
                                err_next = 1'b1;
                            end
                            else
                            begin
                                ucon_next = 2'd0;
                                urem_next = urem_reg - 2'd1;
                                ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, bv, 4'd0);
                            end
                        end
                        else if (utf8_en && bv[7:3] == 5'b11111)
                        begin
                            ta_v = 1'b1;
                            ta = jbt_pkg::mk_tok(jbt_pkg::K_ERR, 8'd0, jbt_pkg::E_LONG_UTF8);
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (utf8_en)
                            begin
                                if (bv[7:5] == 3'b110)
                                begin
                                    urem_next = 2'd1; ucon_next = 2'd0;
                                end
                                else if (bv[7:4] == 4'b1110)
                                begin
                                    urem_next = 2'd2;
                                    ucon_next = (bv == 8'he0) ? 2'd1 : 2'd0;
                                end
                                else if (bv[7:3] == 5'b11110)
                                begin
                                    urem_next = 2'd3;
                                    ucon_next = (bv == 8'hf0) ? 2'd2 :
                                                (bv == 8'hf4) ? 2'd3 : 2'd0;
                                end
                            end
                            if (bv == 8'h5c)
                                mode_next = jbt_pkg::M_ESC;
                            else if (bv == 8'h22)
                            begin
                                ta_v = 1'b1; ta = jbt_pkg::mk_tok(jbt_pkg::K_STREND, 8'd0, 4'd0);
                                mode_next = jbt_pkg::M_LOOKUP;
                            end
                            else
                            begin
                                ta_v = 1'b1; ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, bv, 4'd0);
                            end
                        end
                    end
                    jbt_pkg::M_ESC:
                    begin
                        mode_next = jbt_pkg::M_STR;
                        ta_v = 1'b1;
                        case (bv)
                            8'h22, 8'h5c, 8'h2f: ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, bv, 4'd0);
                            8'h62: ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, 8'h08, 4'd0);
                            8'h66: ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, 8'h0c, 4'd0);
                            8'h6e: ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, 8'h0a, 4'd0);
                            8'h72: ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, 8'h0d, 4'd0);
                            8'h74: ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, 8'h09, 4'd0);
                            8'h75:
                            begin
                                ta_v = 1'b0;
                                mode_next = jbt_pkg::M_UESC; loff_next = 3'd0; cu_next = '0;
                            end
                            default: ta_v = 1'b0; // unknown escape dropped
                        endcase
                    end
                    jbt_pkg::M_UESC:
                    begin
                        if (!hx[4])
                        begin
                            ta_v = 1'b1;
                            ta = jbt_pkg::mk_tok(jbt_pkg::K_ERR, 8'd0, jbt_pkg::E_BAD_UESC);
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cu_next   = {cu_reg[11:0], hx[3:0]};
                            loff_next = loff_reg + 3'd1;
                            if (loff_next >= 3'd4)
                            begin
                                ta_v = 1'b1; tb_v = 1'b1;
                                ta = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, cu_next[15:8], 4'd0);
                                tb = jbt_pkg::mk_tok(jbt_pkg::K_STRBYTE, cu_next[7:0], 4'd0);
                                mode_next = jbt_pkg::M_STR;
                            end
                        end
                    end
                    jbt_pkg::M_INT:
                    begin
                        if (is_dig)
                            iacc_next = (iacc_reg << 3) + (iacc_reg << 1) + {60'd0, dv};
                        else if (bv == 8'h2e)
                            mode_next = jbt_pkg::M_FRAC;
                        else if (bv == 8'h65 || bv == 8'h45)
                            mode_next = jbt_pkg::M_EXPSIGN;
                        else
                        begin
                            ta_v = 1'b1; ta = num_tok; do_lk = 1'b1;
                        end
                    end
                    jbt_pkg::M_FRAC:
                    begin
                        if (is_dig)
                        begin
                            facc_next = (facc_reg << 3) + (facc_reg << 1) + {60'd0, dv};
                            if (flen_reg != 10'h3ff)
                                flen_next = flen_reg + 10'd1;
                        end
                        else if (bv == 8'h65 || bv == 8'h45)
                            mode_next = jbt_pkg::M_EXPSIGN;
                        else
                        begin
                            ta_v = 1'b1; ta = num_tok; do_lk = 1'b1;
                        end
                    end
                    jbt_pkg::M_EXPSIGN:
                    begin
                        mode_next = jbt_pkg::M_EXP;
                        if (bv == 8'h2d)
                            eminus_next = 1'b1;
                        else if (is_dig)
                            eacc_next = {12'd0, dv};
                        else if (bv != 8'h2b)
                        begin
                            mode_next = mode_reg;
                            ta_v = 1'b1;
                            ta = jbt_pkg::mk_tok(jbt_pkg::K_ERR, 8'd0, jbt_pkg::E_BAD_EXP);
                            err_next = 1'b1;
                        end
                    end
                    jbt_pkg::M_EXP:
                    begin
                        if (is_dig)
                            eacc_next = (e20[19:16] != 4'd0) ? 16'hffff : e20[15:0];
                        else
                        begin
                            ta_v = 1'b1; ta = num_tok; do_lk = 1'b1;
                        end
                    end
                    jbt_pkg::M_TRUE, jbt_pkg::M_FALSE, jbt_pkg::M_NULL:
                    begin
                        if (loff_reg >= jbt_pkg::lit_len(which) ||
                            bv != jbt_pkg::lit_char(which, loff_reg))
                        begin
                            ta_v = 1'b1;
                            ta = jbt_pkg::mk_tok(jbt_pkg::K_ERR, 8'd0,
                                                 jbt_pkg::E_BAD_LIT + {2'd0, which});
                            err_next = 1'b1;
                        end
                        else
                        begin
                            loff_next = loff_reg + 3'd1;
                            if (loff_next >= jbt_pkg::lit_len(which))
                            begin
                                ta_v = 1'b1;
                                ta = jbt_pkg::mk_tok(jbt_pkg::K_TRUE + {2'd0, which}, 8'd0, 4'd0);
                                mode_next = jbt_pkg::M_LOOKUP;
                            end
                        end
                    end
                    default:
                    begin
                        if (!(bv == 8'h20 || bv == 8'h0a || bv == 8'h0d || bv == 8'h09))
                            do_lk = 1'b1;
                    end
                endcase

                // Token lookup, also run on the byte that ends a number
                if (do_lk)
                begin
                    if (ta_v)
                    begin
                        minus_next = 1'b0; iacc_next = '0; facc_next = '0; flen_next = '0;
                        eacc_next = '0; eminus_next = 1'b0;
                        mode_next = jbt_pkg::M_LOOKUP;
                    end
                    lk_v = 1'b1;
                    case (bv)
                        8'h3a: lk = jbt_pkg::mk_tok(jbt_pkg::K_COLON, 8'd0, 4'd0);
                        8'h2c: lk = jbt_pkg::mk_tok(jbt_pkg::K_COMMA, 8'd0, 4'd0);
                        8'h7b: lk = jbt_pkg::mk_tok(jbt_pkg::K_LBRACE, 8'd0, 4'd0);
                        8'h7d: lk = jbt_pkg::mk_tok(jbt_pkg::K_RBRACE, 8'd0, 4'd0);
                        8'h5b: lk = jbt_pkg::mk_tok(jbt_pkg::K_LBRACKET, 8'd0, 4'd0);
                        8'h5d: lk = jbt_pkg::mk_tok(jbt_pkg::K_RBRACKET, 8'd0, 4'd0);
                        8'h22:
                        begin
                            lk = jbt_pkg::mk_tok(jbt_pkg::K_STRBEGIN, 8'd0, 4'd0);
                            urem_next = 2'd0; ucon_next = 2'd0;
                            mode_next = jbt_pkg::M_STR;
                        end
                        8'h74:
                        begin
                            lk_v = 1'b0; loff_next = 3'd1; mode_next = jbt_pkg::M_TRUE;
                        end
                        8'h66:
                        begin
                            lk_v = 1'b0; loff_next = 3'd1; mode_next = jbt_pkg::M_FALSE;
                        end
                        8'h6e:
                        begin
                            lk_v = 1'b0; loff_next = 3'd1; mode_next = jbt_pkg::M_NULL;
                        end
                        8'h2d:
                        begin
                            lk_v = 1'b0;
                            iacc_next = '0; facc_next = '0; flen_next = '0;
                            eacc_next = '0; eminus_next = 1'b0;
                            minus_next = 1'b1; mode_next = jbt_pkg::M_INT;
                        end
                        default:
                        begin
                            lk_v = 1'b0;
                            if (is_dig)
                            begin
                                minus_next = 1'b0; facc_next = '0; flen_next = '0;
                                eacc_next = '0; eminus_next = 1'b0;
                                iacc_next = {60'd0, dv}; mode_next = jbt_pkg::M_INT;
                            end
                        end
                    endcase
                    if (lk_v)
                    begin
                        if (ta_v)
                        begin
                            tb_v = 1'b1; tb = lk;
                        end
                        else
                        begin
                            ta_v = 1'b1; ta = lk;
                        end
                    end
                end
            end
        end

        if (tb_v)
            tb.last_of_run = 1'b1;
        else if (ta_v)
            ta.last_of_run = 1'b1;
    end

    assign push.a_v = ta_v;
    assign push.b_v = tb_v;
    assign push.a   = ta;
    assign push.b   = tb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= jbt_pkg::M_LOOKUP;
            urem_reg   <= '0;
            ucon_reg   <= '0;
            loff_reg   <= '0;
            minus_reg  <= 1'b0;
            iacc_reg   <= '0;
            facc_reg   <= '0;
            flen_reg   <= '0;
            eacc_reg   <= '0;
            eminus_reg <= 1'b0;
            cu_reg     <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            urem_reg   <= urem_next;
            ucon_reg   <= ucon_next;
            loff_reg   <= loff_next;
            minus_reg  <= minus_next;
            iacc_reg   <= iacc_next;
            facc_reg   <= facc_next;
            flen_reg   <= flen_next;
            eacc_reg   <= eacc_next;
            eminus_reg <= eminus_next;
            cu_reg     <= cu_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== design/jbt_result_fifo.sv =====
// Small token queue: takes up to two tokens a cycle, gives one while out_ready is high.
module jbt_result_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  jbt_pkg::push_t push,
    output logic           room2,
    output logic [$clog2(jbt_pkg::FIFO_DEPTH):0] level,
    output logic           out_valid,
    input  logic           out_ready,
    output jbt_pkg::tok_t  out_data
);

    localparam int AW = $clog2(jbt_pkg::FIFO_DEPTH);

    jbt_pkg::tok_t mem [jbt_pkg::FIFO_DEPTH];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem[rp_reg];
    assign room2     = cnt_reg <= (AW+1)'(jbt_pkg::FIFO_DEPTH - 2);
    assign level     = cnt_reg;

    always_comb
    begin
        wp_next  = wp_reg + AW'(push.a_v) + AW'(push.b_v);
        rp_next  = rp_reg + AW'(pop);
        cnt_next = cnt_reg + (AW+1)'(push.a_v) + (AW+1)'(push.b_v) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.a_v)
            mem[wp_reg] <= push.a;
        if (push.b_v)
            mem[wp_reg + AW'(1)] <= push.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/json_byte_tokenizer.sv =====
// JSON byte tokenizer top level: input register, lexer and token queue.
//
// Input channel (in_valid/in_ready/in_data): one beat per text byte, or an
// end-of-input beat (req_type = 1) that flushes a pending number or reports
// an unfinished string, exponent sign or literal.
// Output channel (out_valid/out_ready/out_data): one token per beat; a byte
// may give zero, one or two tokens, the last marked by last_of_run.
// Config: cfg_we/cfg_wdata writes utf8_check_enable (reset 1); write only
// while idle.
// An accepted byte waits in the input register until the queue has room for
// two tokens; the lexer then processes it and its tokens are registered into
// the token queue, from whose head the first one leaves.
// Throughput: one byte per cycle while the output drains; a byte that ends a
// number and is itself punctuation, or the last digit of a \u escape, yields
// two tokens, so the output port (one token a cycle) sets the sustained rate.
// The 4-entry token queue lets the input keep flowing while a token waits.
// Reset: lexer returns to token lookup, error flag clears, queue empties.
// Receiver stall: queue fills; once fewer than two slots are free the input
// register holds and in_ready drops. After an error token every later beat
// is accepted and dropped until reset.
module json_byte_tokenizer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  jbt_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output jbt_pkg::tok_t out_data,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);

    localparam int LW = $clog2(jbt_pkg::FIFO_DEPTH) + 1;

    logic           utf8_en_reg;
    logic           iv_reg, iv_next;
    jbt_pkg::in_t   item_reg;
    logic           fire, room2;
    logic [LW-1:0]  level;
    jbt_pkg::push_t push;

    // Held byte is processed once the queue can absorb two tokens
    assign fire     = iv_reg && room2;
    assign in_ready = !iv_reg || fire;
    assign iv_next  = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : iv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg      <= 1'b0;
            utf8_en_reg <= 1'b1;
        end
        else
        begin
            iv_reg <= iv_next;
            if (cfg_we)
                utf8_en_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
    end

    jbt_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .utf8_en (utf8_en_reg),
        .push    (push)
    );

    jbt_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .level     (level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_b_needs_a: assert property (@(posedge clk) disable iff (!rst_n)
        push.b_v |-> push.a_v) else $error("second token without first");
    a_push_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push.a_v |-> fire) else $error("token without processed byte");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LW'(jbt_pkg::FIFO_DEPTH)) else $error("token queue overflow");
    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        push.a_v && !push.b_v |-> push.a.last_of_run) else $error("missing last mark");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the JSON byte tokenizer: random JSON streams against a predictor.
`timescale 1ns / 100ps

module testbench;

    // Kinds and codes the package does not name individually
    localparam logic [3:0] TK_NONE       = 4'd0;
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_EOF_FALSE = jbt_pkg::E_EOF_LIT + 4'd1;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    jbt_pkg::in_t   in_data;
    logic           out_valid;
    logic           out_ready;
    jbt_pkg::tok_t  out_data;
    logic           cfg_we;
    logic           cfg_wdata;

    json_byte_tokenizer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Stimulus bytes waiting for the driver, and tokens waiting for the DUT
    jbt_pkg::in_t  byte_q[$];
    jbt_pkg::tok_t token_q[$];

    int send_idle_pct = 38;
    int recv_idle_pct = 86;
    int fail_count    = 0;
    int beats_sent    = 0;
    int tokens_seen   = 0;

    // ------------------------------------------------------------------
    // Lexer mirror: state kept at the DUT's widths
    // ------------------------------------------------------------------
    logic        utf8_on;
    logic [3:0]  mode;
    logic [1:0]  u8_left;
    logic [1:0]  u8_rule;
    logic [2:0]  lit_pos;
    logic        neg_seen;
    logic [63:0] int_sum;
    logic [63:0] frac_sum;
    logic [9:0]  frac_n;
    logic [15:0] exp_sum;
    logic        exp_neg;
    logic [15:0] ucode;
    logic        halted;
    int          burst_n;
    string       lit_words[3] = '{"true", "false", "null"};

    task automatic clear_num();
        neg_seen = 1'b0;
        int_sum  = '0;
        frac_sum = '0;
        frac_n   = '0;
        exp_sum  = '0;
        exp_neg  = 1'b0;
    endtask

    task automatic mirror_reset();
        utf8_on  = 1'b1;
        mode     = jbt_pkg::M_LOOKUP;
        u8_left  = '0;
        u8_rule  = '0;
        lit_pos  = '0;
        clear_num();
        ucode    = '0;
        halted   = 1'b0;
    endtask

    task automatic emit(logic [3:0] kind, logic [7:0] sb, logic [3:0] code, bit num);
        jbt_pkg::tok_t t;
        t = '0;
        if (burst_n >= 2)
            return;
        t.token_kind  = kind;
        t.string_byte = sb;
        t.error_code  = code;
        if (num)
        begin
            t.int_magnitude = int_sum;
            t.is_negative   = neg_seen;
            if (kind == jbt_pkg::K_REAL)
            begin
                t.frac_digits     = frac_sum;
                t.frac_count      = frac_n;
                t.exp_magnitude   = exp_sum;
                t.exp_is_negative = exp_neg;
            end
        end
        token_q.push_back(t);
        burst_n++;
    endtask

    task automatic raise(logic [3:0] code);
        emit(jbt_pkg::K_ERR, 8'h00, code, 1'b0);
        halted = 1'b1;
    endtask

    task automatic close_num();
        emit((mode == jbt_pkg::M_INT) ? jbt_pkg::K_INT : jbt_pkg::K_REAL, 8'h00,
             ERR_NONE, 1'b1);
        clear_num();
        mode = jbt_pkg::M_LOOKUP;
    endtask

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int hexdig(logic [7:0] b);
        if (is_dig(b)) return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    task automatic start_token(logic [7:0] b);
        case (b)
            ":": emit(jbt_pkg::K_COLON, 8'h00, ERR_NONE, 1'b0);
            ",": emit(jbt_pkg::K_COMMA, 8'h00, ERR_NONE, 1'b0);
            "{": emit(jbt_pkg::K_LBRACE, 8'h00, ERR_NONE, 1'b0);
            "}": emit(jbt_pkg::K_RBRACE, 8'h00, ERR_NONE, 1'b0);
            "[": emit(jbt_pkg::K_LBRACKET, 8'h00, ERR_NONE, 1'b0);
            "]": emit(jbt_pkg::K_RBRACKET, 8'h00, ERR_NONE, 1'b0);
            CH_QUOTE:
            begin
                emit(jbt_pkg::K_STRBEGIN, 8'h00, ERR_NONE, 1'b0);
                u8_left = '0;
                u8_rule = '0;
                mode    = jbt_pkg::M_STR;
            end
            "t":
            begin
                lit_pos = 3'd1;
                mode    = jbt_pkg::M_TRUE;
            end
            "f":
            begin
                lit_pos = 3'd1;
                mode    = jbt_pkg::M_FALSE;
            end
            "n":
            begin
                lit_pos = 3'd1;
                mode    = jbt_pkg::M_NULL;
            end
            "-":
            begin
                clear_num();
                neg_seen = 1'b1;
                mode     = jbt_pkg::M_INT;
            end
            default:
            begin
                if (is_dig(b))
                begin
                    clear_num();
                    int_sum = 64'(b - "0");
                    mode    = jbt_pkg::M_INT;
                end
            end
        endcase
    endtask

    task automatic string_byte_in(logic [7:0] b);
        bit ok;
        if (utf8_on)
        begin
            if (u8_left != 0)
            begin
                case (u8_rule)
                    2'd1:    ok = b >= 8'ha0 && b <= 8'hbf;
                    2'd2:    ok = b >= 8'h90 && b <= 8'hbf;
                    2'd3:    ok = b >= 8'h80 && b <= 8'h8f;
                    default: ok = (b & 8'hc0) == 8'h80;
                endcase
                if (!ok)
                begin
                    raise(jbt_pkg::E_BAD_UTF8);
                    return;
                end
                u8_rule = '0;
                u8_left = u8_left - 2'd1;
                emit(jbt_pkg::K_STRBYTE, b, ERR_NONE, 1'b0);
                return;
            end
            if ((b & 8'he0) == 8'hc0)
            begin
                u8_left = 2'd1;
                u8_rule = 2'd0;
            end
            else if ((b & 8'hf0) == 8'he0)
            begin
                u8_left = 2'd2;
                u8_rule = (b == 8'he0) ? 2'd1 : 2'd0;
            end
            else if ((b & 8'hf8) == 8'hf0)
            begin
                u8_left = 2'd3;
                u8_rule = (b == 8'hf0) ? 2'd2 : (b == 8'hf4) ? 2'd3 : 2'd0;
            end
            else if ((b & 8'hf8) == 8'hf8)
            begin
                raise(jbt_pkg::E_LONG_UTF8);
                return;
            end
        end
        if (b == CH_BSL)
            mode = jbt_pkg::M_ESC;
        else if (b == CH_QUOTE)
        begin
            emit(jbt_pkg::K_STREND, 8'h00, ERR_NONE, 1'b0);
            mode = jbt_pkg::M_LOOKUP;
        end
        else
            emit(jbt_pkg::K_STRBYTE, b, ERR_NONE, 1'b0);
    endtask

    task automatic literal_in(logic [7:0] b, int which);
        int len;
        len = lit_words[which].len();
        if (lit_pos >= len || b != lit_words[which][lit_pos])
        begin
            raise(jbt_pkg::E_BAD_LIT + 4'(which));
            return;
        end
        lit_pos = lit_pos + 3'd1;
        if (lit_pos >= len)
        begin
            emit(jbt_pkg::K_TRUE + 4'(which), 8'h00, ERR_NONE, 1'b0);
            mode = jbt_pkg::M_LOOKUP;
        end
    endtask

    // Work out the tokens one accepted beat produces
    task automatic predict_beat(jbt_pkg::in_t x);
        logic [7:0]    b;
        int            v;
        int            e;
        jbt_pkg::tok_t t;
        b = x.byte_value;
        if (halted)
            return;
        burst_n = 0;
        if (x.req_type)
        begin
            case (mode)
                jbt_pkg::M_STR, jbt_pkg::M_ESC, jbt_pkg::M_UESC:
                    raise(jbt_pkg::E_EOF_STR);
                jbt_pkg::M_INT, jbt_pkg::M_FRAC, jbt_pkg::M_EXP:
                    close_num();
                jbt_pkg::M_EXPSIGN: raise(jbt_pkg::E_EOF_EXPSIGN);
                jbt_pkg::M_TRUE:    raise(jbt_pkg::E_EOF_LIT);
                jbt_pkg::M_FALSE:   raise(ERR_EOF_FALSE);
                jbt_pkg::M_NULL:    raise(jbt_pkg::E_EOF_LIT + 4'd2);
                default:            ;
            endcase
            if (!halted)
            begin
                clear_num();
                mode = jbt_pkg::M_LOOKUP;
            end
        end
        else
        begin
            case (mode)
                jbt_pkg::M_STR: string_byte_in(b);
                jbt_pkg::M_ESC:
                begin
                    mode = jbt_pkg::M_STR;
                    case (b)
                        CH_QUOTE, CH_BSL, "/": emit(jbt_pkg::K_STRBYTE, b, ERR_NONE, 1'b0);
                        "b": emit(jbt_pkg::K_STRBYTE, 8'h08, ERR_NONE, 1'b0);
                        "f": emit(jbt_pkg::K_STRBYTE, 8'h0c, ERR_NONE, 1'b0);
                        "n": emit(jbt_pkg::K_STRBYTE, 8'h0a, ERR_NONE, 1'b0);
                        "r": emit(jbt_pkg::K_STRBYTE, 8'h0d, ERR_NONE, 1'b0);
                        "t": emit(jbt_pkg::K_STRBYTE, 8'h09, ERR_NONE, 1'b0);
                        "u":
                        begin
                            mode    = jbt_pkg::M_UESC;
                            lit_pos = '0;
                            ucode   = '0;
                        end
                        default: ;
                    endcase
                end
                jbt_pkg::M_UESC:
                begin
                    v = hexdig(b);
                    if (v < 0)
                        raise(jbt_pkg::E_BAD_UESC);
                    else
                    begin
                        ucode   = {ucode[11:0], 4'(v)};
                        lit_pos = lit_pos + 3'd1;
                        if (lit_pos >= 4)
                        begin
                            emit(jbt_pkg::K_STRBYTE, ucode[15:8], ERR_NONE, 1'b0);
                            emit(jbt_pkg::K_STRBYTE, ucode[7:0], ERR_NONE, 1'b0);
                            mode = jbt_pkg::M_STR;
                        end
                    end
                end
                jbt_pkg::M_INT:
                begin
                    if (is_dig(b))
                        int_sum = int_sum * 64'd10 + 64'(b - "0");
                    else if (b == ".")
                        mode = jbt_pkg::M_FRAC;
                    else if (b == "e" || b == "E")
                        mode = jbt_pkg::M_EXPSIGN;
                    else
                    begin
                        close_num();
                        start_token(b);
                    end
                end
                jbt_pkg::M_FRAC:
                begin
                    if (is_dig(b))
                    begin
                        frac_sum = frac_sum * 64'd10 + 64'(b - "0");
                        if (frac_n < 10'd1023)
                            frac_n = frac_n + 10'd1;
                    end
                    else if (b == "e" || b == "E")
                        mode = jbt_pkg::M_EXPSIGN;
                    else
                    begin
                        close_num();
                        start_token(b);
                    end
                end
                jbt_pkg::M_EXPSIGN:
                begin
                    if (b == "-")
                    begin
                        exp_neg = 1'b1;
                        mode    = jbt_pkg::M_EXP;
                    end
                    else if (is_dig(b))
                    begin
                        exp_sum = 16'(b - "0");
                        mode    = jbt_pkg::M_EXP;
                    end
                    else if (b == "+")
                        mode = jbt_pkg::M_EXP;
                    else
                        raise(jbt_pkg::E_BAD_EXP);
                end
                jbt_pkg::M_EXP:
                begin
                    if (is_dig(b))
                    begin
                        e = exp_sum * 10 + (b - "0");
                        exp_sum = (e > 65535) ? 16'hffff : 16'(e);
                    end
                    else
                    begin
                        close_num();
                        start_token(b);
                    end
                end
                jbt_pkg::M_TRUE:  literal_in(b, 0);
                jbt_pkg::M_FALSE: literal_in(b, 1);
                jbt_pkg::M_NULL:  literal_in(b, 2);
                default:
                begin
                    if (!(b == " " || b == 8'h0a || b == 8'h0d || b == 8'h09))
                        start_token(b);
                end
            endcase
        end
        if (burst_n > 0)
        begin
            t = token_q.pop_back();
            t.last_of_run = 1'b1;
            token_q.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic put_byte(logic [7:0] b);
        jbt_pkg::in_t x;
        x.req_type   = 1'b0;
        x.byte_value = b;
        byte_q.push_back(x);
    endtask

    task automatic put_eoi();
        jbt_pkg::in_t x;
        x.req_type   = 1'b1;
        x.byte_value = 8'($urandom_range(255));
        byte_q.push_back(x);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [7:0] cont_byte(logic [7:0] lo, logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] hex_char();
        string hx;
        hx = "0123456789abcdefABCDEF";
        return hx[$urandom_range(21)];
    endfunction

    task automatic gen_string(bit check);
        logic [7:0] b;
        string      esc;
        int         len;
        esc = "\"\\/bfnrt";
        len = $urandom_range(6);
        put_byte(CH_QUOTE);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    do b = 8'($urandom_range(127));
                    while (b == CH_QUOTE || b == CH_BSL);
                    put_byte(b);
                end
                3:
                begin
                    put_byte(CH_BSL);
                    put_byte(esc[$urandom_range(7)]);
                end
                4:
                begin
                    put_byte(CH_BSL);
                    put_byte("u");
                    repeat (4) put_byte(hex_char());
                end
                5:
                begin
                    // unknown escape letter is dropped
                    do b = 8'($urandom_range(255));
                    while (b == CH_QUOTE || b == CH_BSL || b == "/" || b == "b" ||
                           b == "f" || b == "n" || b == "r" || b == "t" || b == "u");
                    put_byte(CH_BSL);
                    put_byte(b);
                end
                6:
                begin
                    // stray continuation byte passes as content
                    put_byte(cont_byte(8'h80, 8'hbf));
                end
                default:
                begin
                    if (!check)
                    begin
                        do b = 8'($urandom_range(255));
                        while (b == CH_QUOTE || b == CH_BSL);
                        put_byte(b);
                    end
                    else
                    begin
                        case ($urandom_range(5))
                            0:
                            begin
                                put_byte(cont_byte(8'hc0, 8'hdf));
                                put_byte(cont_byte(8'h80, 8'hbf));
                            end
                            1:
                            begin
                                put_byte(8'he0);
                                put_byte(cont_byte(8'ha0, 8'hbf));
                                put_byte(cont_byte(8'h80, 8'hbf));
                            end
                            2:
                            begin
                                put_byte(cont_byte(8'he1, 8'hef));
                                put_byte(cont_byte(8'h80, 8'hbf));
                                put_byte(cont_byte(8'h80, 8'hbf));
                            end
                            3:
                            begin
                                put_byte(8'hf0);
                                put_byte(cont_byte(8'h90, 8'hbf));
                                repeat (2) put_byte(cont_byte(8'h80, 8'hbf));
                            end
                            4:
                            begin
                                put_byte(8'hf4);
                                put_byte(cont_byte(8'h80, 8'h8f));
                                repeat (2) put_byte(cont_byte(8'h80, 8'hbf));
                            end
                            default:
                            begin
                                put_byte(cont_byte(8'hf1, 8'hf3));
                                repeat (3) put_byte(cont_byte(8'h80, 8'hbf));
                            end
                        endcase
                    end
                end
            endcase
        end
        put_byte(CH_QUOTE);
    endtask

    task automatic put_digits(int n);
        repeat (n) put_byte(8'("0" + $urandom_range(9)));
    endtask

    task automatic gen_number(int frac_len);
        string seps;
        bit    neg;
        seps = " ,]}:[\t";
        neg  = $urandom_range(2) == 0;
        if (neg)
            put_byte("-");
        if ($urandom_range(15) == 0)
            put_digits(21);              // wraps the 64-bit integer part
        else
            put_digits(neg ? $urandom_range(4) : $urandom_range(4, 1));
        if (frac_len > 0)
        begin
            put_byte(".");
            put_digits(frac_len);
        end
        else if ($urandom_range(2) == 0)
        begin
            put_byte(".");
            put_digits($urandom_range($urandom_range(7) == 0 ? 22 : 4));
        end
        if ($urandom_range(2) == 0)
        begin
            put_byte($urandom_range(1) ? "e" : "E");
            case ($urandom_range(3))
                0:       put_byte("+");
                1:       put_byte("-");
                default: put_byte(8'("0" + $urandom_range(9)));
            endcase
            put_digits($urandom_range($urandom_range(7) == 0 ? 7 : 3));
        end
        if ($urandom_range(5) == 0)
            put_eoi();
        else
            put_byte(seps[$urandom_range(6)]);
    endtask

    task automatic gen_token(bit check);
        string punct;
        string ws;
        logic [7:0] b;
        punct = ":,{}[]";
        ws    = " \t\r\n";
        case ($urandom_range(11))
            0, 1:    put_byte(punct[$urandom_range(5)]);
            2:       put_text(lit_words[$urandom_range(2)]);
            3, 4, 5: gen_string(check);
            6, 7, 8: gen_number(0);
            9:       put_byte(ws[$urandom_range(3)]);
            10:
            begin
                // random filler between tokens, ignored unless it is punctuation
                do b = 8'($urandom_range(255));
                while (b == CH_QUOTE || b == "t" || b == "f" || b == "n" ||
                       b == "-" || is_dig(b));
                put_byte(b);
            end
            default: put_eoi();
        endcase
    endtask

    // One terminating error: everything after it is dropped
    task automatic gen_fault();
        case ($urandom_range(12))
            0:  begin put_byte(CH_QUOTE); put_byte(8'he0); put_byte(8'h80); end
            1:  begin put_byte(CH_QUOTE); put_byte(cont_byte(8'hf8, 8'hff)); end
            2:  begin put_text("\"\\u1"); put_byte("g"); end
            3:  put_text("1ex");
            4:  put_text("trx");
            5:  put_text("fals!");
            6:  put_text("nul?");
            7:  begin put_text("\"ab"); put_eoi(); end
            8:  begin put_text("7e"); put_eoi(); end
            9:  begin put_text("tr"); put_eoi(); end
            10: begin put_text("fa"); put_eoi(); end
            11: begin put_text("nu"); put_eoi(); end
            default: begin put_byte(CH_QUOTE); put_byte(8'hf4); put_byte(8'h90); end
        endcase
        repeat (6) put_byte(8'($urandom_range(255)));
        put_eoi();
    endtask

    // ------------------------------------------------------------------
    // Driver: one beat at a time from byte_q
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_beat(in_data);
                beats_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= byte_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        jbt_pkg::tok_t want;
        if (rst_n && out_valid && out_ready)
        begin
            tokens_seen++;
            if (token_q.size() == 0)
                report("unexpected token kind", 64'(out_data.token_kind), 64'(TK_NONE));
            else
            begin
                want = token_q.pop_front();
                if (out_data.token_kind != want.token_kind)
                    report("token_kind", 64'(out_data.token_kind), 64'(want.token_kind));
                if (out_data.string_byte != want.string_byte)
                    report("string_byte", 64'(out_data.string_byte), 64'(want.string_byte));
                if (out_data.int_magnitude != want.int_magnitude)
                    report("int_magnitude", out_data.int_magnitude, want.int_magnitude);
                if (out_data.is_negative != want.is_negative)
                    report("is_negative", 64'(out_data.is_negative), 64'(want.is_negative));
                if (out_data.frac_digits != want.frac_digits)
                    report("frac_digits", out_data.frac_digits, want.frac_digits);
                if (out_data.frac_count != want.frac_count)
                    report("frac_count", 64'(out_data.frac_count), 64'(want.frac_count));
                if (out_data.exp_magnitude != want.exp_magnitude)
                    report("exp_magnitude", 64'(out_data.exp_magnitude),
                           64'(want.exp_magnitude));
                if (out_data.exp_is_negative != want.exp_is_negative)
                    report("exp_is_negative", 64'(out_data.exp_is_negative),
                           64'(want.exp_is_negative));
                if (out_data.error_code != want.error_code)
                    report("error_code", 64'(out_data.error_code), 64'(want.error_code));
                if (out_data.last_of_run != want.last_of_run)
                    report("last_of_run", 64'(out_data.last_of_run), 64'(want.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (byte_q.size() > 0 || in_valid || token_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_utf8_check(logic v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        utf8_on    = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b1;
        mirror_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Phase 1: UTF-8 checking on (reset value), directed items first
        put_text("{[]}:, \t");
        put_text("truefalsenull");
        put_text("\"\\n\\u00Ff\\q");
        put_byte(8'he0); put_byte(8'ha0); put_byte(8'h80);
        put_byte(8'hf0); put_byte(8'h90); put_byte(8'h80); put_byte(8'h80);
        put_byte(8'hf4); put_byte(8'h8f); put_byte(8'hbf); put_byte(8'hbf);
        put_byte(8'h80); put_byte(CH_QUOTE);
        put_text("-,1e5 2.5e-]18446744073709551616}");
        put_text("9.01E+99999"); put_eoi();
        put_eoi();
        repeat (50) gen_token(1'b1);
        wait_drained();

        // Phase 2: checking off, sender and receiver idling swapped
        write_utf8_check(1'b0);
        send_idle_pct = 86;
        recv_idle_pct = 38;
        repeat (50) gen_token(1'b0);
        gen_number(30);                  // fraction digits wrap 64 bits
        wait_drained();

        // Phase 3: checking back on, no idling, ends with one sticky error
        write_utf8_check(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (50) gen_token(1'b1);
        gen_fault();
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d beats and checked %0d tokens over three stall patterns,",
                 beats_sent, tokens_seen);
        $display("with UTF-8 checking toggled and a sticky error at the end.");
        if (fail_count == 0 && token_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout waiting for the tokenizer");
        $display("Regression FAIL");
        $finish;
    end

endmodule
